FILE: rtl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

	// Byte classes decided by the front end
	typedef enum logic [2:0] {
		CL_END   = 3'd0,	// zero terminator
		CL_ASCII = 3'd1,	// 0x01..0x7F
		CL_LEAD2 = 3'd2,	// 0xC0..0xDF
		CL_LEAD3 = 3'd3,	// 0xE0..0xEF
		CL_CONT  = 3'd4,	// 0x80..0xBF
		CL_STRAY = 3'd5		// 0xF0..0xFF
	} byte_class_t;

	// Held-byte counts
	localparam logic [1:0] HELD_NONE   = 2'd0;
	localparam logic [1:0] HELD_LEAD   = 2'd1;
	localparam logic [1:0] HELD_SECOND = 2'd2;

	localparam logic [7:0] MASK_C0   = 8'hC0;
	localparam logic [7:0] MASK_E0   = 8'hE0;
	localparam logic [7:0] MASK_F0   = 8'hF0;
	localparam logic [7:0] PAT_CONT  = 8'h80;
	localparam logic [7:0] PAT_LEAD2 = 8'hC0;
	localparam logic [7:0] PAT_LEAD3 = 8'hE0;

	// One classified request as it sits in the queue
	typedef struct packed {
		byte_class_t cls;
		logic [7:0]  data;
	} item_t;

endpackage

FILE: rtl/utf8d_front.sv
// Front end: classifies each incoming byte.
`timescale 1ns / 1ps

module utf8d_front
	import utf8d_pkg::*;
(
	input  logic [7:0] data_byte,
	output item_t      item
);

	byte_class_t cls;

	always_comb begin
		if (data_byte == 8'h00) begin
			cls = CL_END;
		end else if (data_byte[7] == 1'b0) begin
			cls = CL_ASCII;
		end else if ((data_byte & MASK_C0) == PAT_CONT) begin
			cls = CL_CONT;
		end else if ((data_byte & MASK_E0) == PAT_LEAD2) begin
			cls = CL_LEAD2;
		end else if ((data_byte & MASK_F0) == PAT_LEAD3) begin
			cls = CL_LEAD3;
		end else begin
			cls = CL_STRAY;
		end
	end

	assign item.cls  = cls;
	assign item.data = data_byte;

endmodule

FILE: rtl/utf8d_queue.sv
// Short request queue between front end and back end.
`timescale 1ns / 1ps

module utf8d_queue
	import utf8d_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/utf8d_back.sv
// Back end: held-byte sequencing, character assembly and output register.
`timescale 1ns / 1ps

module utf8d_back
	import utf8d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  item_t       q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_point,
	output logic        char_valid,
	output logic        string_end
);

	logic [7:0]  held_lead_q;
	logic [7:0]  held_second_q;
	logic [1:0]  held_count_q;
	logic        out_valid_q;
	logic [15:0] code_point_q;
	logic        char_valid_q;
	logic        string_end_q;

	logic [7:0]  lead_d;
	logic [7:0]  second_d;
	logic [1:0]  count_d;
	logic [15:0] cp_d;
	logic        valid_d;
	logic        end_d;
	logic [7:0]  b;

	assign q_pop = q_not_empty && (!out_valid_q || !out_stall);
	assign b     = q_head.data;

	always_comb begin
		lead_d   = held_lead_q;
		second_d = held_second_q;
		count_d  = held_count_q;
		cp_d     = '0;
		valid_d  = 1'b0;
		end_d    = 1'b0;
		if (q_head.cls == CL_END) begin
			end_d    = 1'b1;
			lead_d   = '0;
			second_d = '0;
			count_d  = HELD_NONE;
		end else if (held_count_q == HELD_LEAD && q_head.cls == CL_CONT) begin
			if ((held_lead_q & MASK_E0) == PAT_LEAD2) begin
				cp_d     = {5'd0, held_lead_q[4:0], b[5:0]};
				valid_d  = 1'b1;
				lead_d   = '0;
				second_d = '0;
				count_d  = HELD_NONE;
			end else begin
				second_d = b;
				count_d  = HELD_SECOND;
			end
		end else if (held_count_q == HELD_SECOND && q_head.cls == CL_CONT) begin
			cp_d     = {held_lead_q[3:0], held_second_q[5:0], b[5:0]};
			valid_d  = 1'b1;
			lead_d   = '0;
			second_d = '0;
			count_d  = HELD_NONE;
		end else begin
			// fresh start: anything held is dropped
			lead_d   = '0;
			second_d = '0;
			count_d  = HELD_NONE;
			case (q_head.cls)
				CL_ASCII: begin
					cp_d    = {8'd0, b};
					valid_d = 1'b1;
				end
				CL_LEAD2, CL_LEAD3: begin
					lead_d  = b;
					count_d = HELD_LEAD;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lead_q   <= '0;
			held_second_q <= '0;
			held_count_q  <= HELD_NONE;
			out_valid_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				held_lead_q   <= lead_d;
				held_second_q <= second_d;
				held_count_q  <= count_d;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			code_point_q <= cp_d;
			char_valid_q <= valid_d;
			string_end_q <= end_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = code_point_q;
	assign char_valid = char_valid_q;
	assign string_end = string_end_q;

endmodule

FILE: rtl/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  in      | request   | in_valid/in_stall  | data_byte[7:0]
//  out     | result    | out_valid/out_stall| code_point[15:0], char_valid,
//          |           |                    | string_end
//
//  One request per cycle sustained while out_stall stays low, one result for every request.
//  A result is shown in the cycle after its request leaves the queue; with
//  an empty queue it passes the queue storage and then the output register.
//  in_stall rises only when the queue holds QUEUE_DEPTH requests, so a
//  stalled output keeps taking requests until the queue fills.
//  arst_n clears the held bytes, the queue and the output valid; no
//  clearing pass is needed after reset.
//
//  Front end classifies each byte (terminator, ASCII, lead, continuation,
//  stray) and writes it into the queue; the back end holds partial
//  sequences, assembles characters and owns the output register.

module utf8_to_ucs2_decoder
	import utf8d_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2	// two or more
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_point,
	output logic        char_valid,
	output logic        string_end
);

	item_t front_item;
	item_t q_head;
	logic  q_full;
	logic  q_not_empty;
	logic  q_pop;
	logic  q_push;

	// request accepted straight into the queue
	assign q_push   = in_valid && !q_full;
	assign in_stall = q_full;

	utf8d_front u_front (
		.data_byte (data_byte),
		.item      (front_item)
	);

	utf8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	utf8d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_point  (code_point),
		.char_valid  (char_valid),
		.string_end  (string_end)
	);

endmodule

FILE: rtl/utf8d_chk.sv
// Port-level checker for the UTF-8 to UCS-2 decoder, with its bind.
`timescale 1ns / 1ps

module utf8d_chk #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  data_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] code_point,
	input logic        char_valid,
	input logic        string_end
);

	// requests accepted but not yet delivered
	logic [7:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 8'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 8'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_point) &&
			$stable(char_valid) && $stable(string_end))
		else $error("result changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 8'd0)
		else $error("result without an outstanding request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 8'(QUEUE_DEPTH + 1))
		else $error("more requests outstanding than storage allows");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> code_point == 16'd0)
		else $error("code point set without a character");

	a_end_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> !char_valid)
		else $error("terminator flagged as a character");

endmodule

bind utf8_to_ucs2_decoder utf8d_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (.*);
